[rtl/gspd_pkg.sv]
// gspd_pkg: shared types, widths, register indexes and the proportional gain table
// for the gain-scheduled steering PD block. No dependencies.
`timescale 1ns / 1ps

package gspd_pkg;

    // Field and datapath widths
    localparam int LEVEL_W  = 16;
    localparam int LIMIT_W  = 8;
    localparam int DEV_W    = 18;
    localparam int EXT_W    = 20;
    localparam int ERR_W    = 18;
    localparam int DIFF_W   = 19;
    localparam int KP_W     = 16;
    localparam int KP_IDX_W = 6;
    localparam int MUL_A_W  = 19;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 41;
    localparam int FRAC_W   = 12;
    localparam int STEER_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 16;

    // Full-lock steering level
    localparam int LOCK_LEVEL = 210;
    localparam logic signed [ACC_W-1:0] LOCK_Q12     = ACC_W'(LOCK_LEVEL * (2 ** FRAC_W));
    localparam logic signed [ACC_W-1:0] LOCK_Q12_NEG = -LOCK_Q12;
    localparam logic signed [STEER_W-1:0] LOCK_STEER     = STEER_W'(LOCK_LEVEL);
    localparam logic signed [STEER_W-1:0] LOCK_STEER_NEG = -LOCK_STEER;

    // Error saturation bounds (18-bit signed) in the extended width
    localparam logic signed [EXT_W-1:0] ERR_MAX = EXT_W'((2 ** (ERR_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0] ERR_MIN = EXT_W'(-(2 ** (ERR_W - 1)));

    // Output saturation bounds and truncate-toward-zero bias
    localparam logic signed [ACC_W-1:0] STEER_MAX = ACC_W'((2 ** (STEER_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] STEER_MIN = ACC_W'(-(2 ** (STEER_W - 1)));
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((2 ** FRAC_W) - 1);

    // Signal-lost thresholds
    localparam logic signed [DEV_W-1:0] LOST_SIDE = DEV_W'(4);
    localparam logic signed [EXT_W-1:0] LOST_MID  = EXT_W'(3);

    // Lock state codes
    localparam logic [1:0] LOCK_NONE  = 2'd0;
    localparam logic [1:0] LOCK_LEFT  = 2'd1;
    localparam logic [1:0] LOCK_RIGHT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LIM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_LIM    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd6;

    // Proportional gain in Q4.12, indexed by |error| below 64; saturated above
    localparam logic [KP_W-1:0] KP_SAT = '1;
    localparam logic [KP_W-1:0] KP_TABLE [2 ** KP_IDX_W] = '{
        16'd0,     16'd702,   16'd1404,  16'd2106,  16'd2808,  16'd3510,  16'd4212,  16'd4915,
        16'd5909,  16'd6904,  16'd7899,  16'd8893,  16'd9888,  16'd10883, 16'd11878, 16'd13516,
        16'd15154, 16'd16793, 16'd18431, 16'd20070, 16'd21708, 16'd23347, 16'd24657, 16'd25968,
        16'd27279, 16'd28589, 16'd29900, 16'd31211, 16'd32521, 16'd33832, 16'd35143, 16'd36454,
        16'd37764, 16'd39075, 16'd40386, 16'd41696, 16'd43007, 16'd44318, 16'd45628, 16'd46939,
        16'd48250, 16'd49561, 16'd50871, 16'd52182, 16'd53493, 16'd54803, 16'd56114, 16'd57425,
        16'd58735, 16'd60046, 16'd61357, 16'd62668, 16'd63978, 16'd65289, 16'd65535, 16'd65535,
        16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535
    };

    // Channel payloads
    typedef struct packed {
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] middle_level;
        logic [LEVEL_W-1:0] right_level;
    } in_item_t;

    typedef struct packed {
        logic signed [STEER_W-1:0] steer_value;
        logic                      held_at_lock;
        logic [1:0]                lock_state;
    } out_item_t;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;    // register a*b
        logic acc_load;  // acc = product
        logic acc_add;   // acc += product << FRAC_W
    } mac_ctrl_t;

endpackage

[rtl/gspd_mac.sv]
// gspd_mac: shared signed multiplier with a registered product and accumulator.
// Depends on gspd_pkg.
`timescale 1ns / 1ps

module gspd_mac (
    input  logic                                  clk,
    input  gspd_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [gspd_pkg::MUL_A_W-1:0]   a,
    input  logic signed [gspd_pkg::MUL_B_W-1:0]   b,
    output logic signed [gspd_pkg::ACC_W-1:0]     acc
);

    logic signed [gspd_pkg::PROD_W-1:0] prod_reg;
    logic signed [gspd_pkg::ACC_W-1:0]  acc_reg;
    logic signed [gspd_pkg::ACC_W-1:0]  prod_ext;

    assign prod_ext = gspd_pkg::ACC_W'(prod_reg);
    assign acc      = acc_reg;

    // Product register
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= a * b;
        end
    end

    // Accumulator: load plain, add scaled to Q.12
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_load)
        begin
            acc_reg <= prod_ext;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + (prod_ext <<< gspd_pkg::FRAC_W);
        end
    end

endmodule

[rtl/gain_scheduled_steering_pd.sv]
// gain_scheduled_steering_pd: top level, sequencer, config registers and output stage.
// Depends on gspd_pkg and gspd_mac.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_data   (gspd_pkg::in_item_t)
// out       output     out_valid / out_ready out_data  (gspd_pkg::out_item_t)
// cfg       input      cfg_we                cfg_index, cfg_data
//
// The result register loads on the edge that returns the sequencer to idle, where in_ready
// rises again, so no new transaction is taken until the last is through. The sequencer
// walks deviation, error, gain, two multiplies on the shared unit and an accumulate, or
// goes from error straight to the result under the signal-lost hold. in_ready is high
// only in idle. The result register holds one transaction; a stalled out channel holds
// the sequencer in its final step. Reset clears state and loads register defaults.

module gain_scheduled_steering_pd (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  gspd_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output gspd_pkg::out_item_t                out_data,
    input  logic                               cfg_we,
    input  logic [gspd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gspd_pkg::CFG_W-1:0]         cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DEV  = 8'b0000_0010,
        ST_ERR  = 8'b0000_0100,
        ST_GAIN = 8'b0000_1000,
        ST_MUL1 = 8'b0001_0000,
        ST_MUL2 = 8'b0010_0000,
        ST_ACC  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [gspd_pkg::LEVEL_W-1:0] left_base_reg, mid_base_reg, right_base_reg;
    logic [gspd_pkg::LIMIT_W-1:0] left_lim_reg, right_lim_reg, mid_lim_reg, dgain_reg;

    // Controller state
    logic [1:0]                          lock_mode_reg;
    logic signed [gspd_pkg::ERR_W-1:0]   prev_err_reg;

    // Working registers
    gspd_pkg::in_item_t                  in_reg;
    logic signed [gspd_pkg::DEV_W-1:0]   dl_reg, dr_reg, dm_reg;
    logic signed [gspd_pkg::DEV_W-1:0]   dl_next, dr_next, dm_next;
    logic signed [gspd_pkg::ERR_W-1:0]   err_reg, err_next;
    logic signed [gspd_pkg::DIFF_W-1:0]  diff_reg, diff_next;
    logic [gspd_pkg::KP_W-1:0]           kp_reg, kp_next;
    logic                                hold_reg, lost;

    // Output stage
    logic                                out_valid_reg;
    gspd_pkg::out_item_t                 out_reg, result;
    logic                                commit;

    // Shared unit
    gspd_pkg::mac_ctrl_t                 mac_ctrl;
    logic signed [gspd_pkg::MUL_A_W-1:0] mac_a;
    logic signed [gspd_pkg::MUL_B_W-1:0] mac_b;
    logic signed [gspd_pkg::ACC_W-1:0]   mac_acc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign commit    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_base_reg  <= '0;
            mid_base_reg   <= '0;
            right_base_reg <= '0;
            left_lim_reg   <= 8'd17;
            right_lim_reg  <= 8'd19;
            mid_lim_reg    <= 8'd14;
            dgain_reg      <= 8'd37;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gspd_pkg::CFG_LEFT_BASE:  left_base_reg  <= cfg_data;
                gspd_pkg::CFG_MID_BASE:   mid_base_reg   <= cfg_data;
                gspd_pkg::CFG_RIGHT_BASE: right_base_reg <= cfg_data;
                gspd_pkg::CFG_LEFT_LIM:   left_lim_reg   <= cfg_data[gspd_pkg::LIMIT_W-1:0];
                gspd_pkg::CFG_RIGHT_LIM:  right_lim_reg  <= cfg_data[gspd_pkg::LIMIT_W-1:0];
                gspd_pkg::CFG_MID_LIM:    mid_lim_reg    <= cfg_data[gspd_pkg::LIMIT_W-1:0];
                gspd_pkg::CFG_DERIV_GAIN: dgain_reg      <= cfg_data[gspd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_DEV;
            ST_DEV:  state_next = ST_ERR;
            ST_ERR:  state_next = lost ? ST_DONE : ST_GAIN;
            ST_GAIN: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_ACC;
            ST_ACC:  state_next = ST_DONE;
            ST_DONE: if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Deviations: subtract baselines, clip sides, middle forced to zero or below
    always_comb
    begin
        logic signed [gspd_pkg::DEV_W-1:0] dl_raw, dr_raw, lc_s, rc_s;
        dl_raw = $signed({2'b00, in_reg.left_level}) - $signed({2'b00, left_base_reg});
        dr_raw = $signed({2'b00, in_reg.right_level}) - $signed({2'b00, right_base_reg});
        lc_s   = $signed({{(gspd_pkg::DEV_W - gspd_pkg::LIMIT_W){1'b0}}, left_lim_reg});
        rc_s   = $signed({{(gspd_pkg::DEV_W - gspd_pkg::LIMIT_W){1'b0}}, right_lim_reg});
        dl_next = (dl_raw > lc_s) ? lc_s : dl_raw;
        dr_next = (dr_raw > rc_s) ? rc_s : dr_raw;
        if (in_reg.middle_level > mid_base_reg)
        begin
            dm_next = '0;
        end
        else
        begin
            dm_next = $signed({2'b00, in_reg.middle_level}) - $signed({2'b00, mid_base_reg});
        end
    end

    // Signal-lost check and position error
    always_comb
    begin
        logic signed [gspd_pkg::EXT_W-1:0] dl_x, dr_x, dm_x, lc_x, rc_x, mc_x, e_raw;
        logic                              locked;
        dl_x = gspd_pkg::EXT_W'(dl_reg);
        dr_x = gspd_pkg::EXT_W'(dr_reg);
        dm_x = gspd_pkg::EXT_W'(dm_reg);
        lc_x = $signed({{(gspd_pkg::EXT_W - gspd_pkg::LIMIT_W){1'b0}}, left_lim_reg});
        rc_x = $signed({{(gspd_pkg::EXT_W - gspd_pkg::LIMIT_W){1'b0}}, right_lim_reg});
        mc_x = $signed({{(gspd_pkg::EXT_W - gspd_pkg::LIMIT_W){1'b0}}, mid_lim_reg});

        locked = (lock_mode_reg == gspd_pkg::LOCK_LEFT) ||
                 (lock_mode_reg == gspd_pkg::LOCK_RIGHT);
        lost = locked && (dl_reg < gspd_pkg::LOST_SIDE) && (dr_reg < gspd_pkg::LOST_SIDE) &&
               (dm_x < (gspd_pkg::LOST_MID - mc_x));

        if (dl_reg >= dr_reg)
        begin
            e_raw = (dm_x >= -mc_x) ? -dm_x : (-dm_x + lc_x - dl_x);
        end
        else
        begin
            e_raw = (dm_x >= -mc_x) ? dm_x : (dm_x - rc_x + dr_x);
        end

        if (e_raw > gspd_pkg::ERR_MAX)
        begin
            err_next = gspd_pkg::ERR_MAX[gspd_pkg::ERR_W-1:0];
        end
        else if (e_raw < gspd_pkg::ERR_MIN)
        begin
            err_next = gspd_pkg::ERR_MIN[gspd_pkg::ERR_W-1:0];
        end
        else
        begin
            err_next = e_raw[gspd_pkg::ERR_W-1:0];
        end
    end

    // Gain lookup on |error| and change of error
    always_comb
    begin
        logic [gspd_pkg::ERR_W-1:0] mag;
        mag = err_reg[gspd_pkg::ERR_W-1] ? gspd_pkg::ERR_W'(-err_reg) : err_reg;
        if (mag[gspd_pkg::ERR_W-1:gspd_pkg::KP_IDX_W] != '0)
        begin
            kp_next = gspd_pkg::KP_SAT;
        end
        else
        begin
            kp_next = gspd_pkg::KP_TABLE[mag[gspd_pkg::KP_IDX_W-1:0]];
        end
        diff_next = gspd_pkg::DIFF_W'(err_reg) - gspd_pkg::DIFF_W'(prev_err_reg);
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        if (state_reg == ST_DEV)
        begin
            dl_reg <= dl_next;
            dr_reg <= dr_next;
            dm_reg <= dm_next;
        end
        if (state_reg == ST_ERR)
        begin
            err_reg  <= err_next;
            hold_reg <= lost;
        end
        if (state_reg == ST_GAIN)
        begin
            kp_reg   <= kp_next;
            diff_reg <= diff_next;
        end
    end

    // Shared unit: kp*e, then derivative_gain*(e - previous), then accumulate
    always_comb
    begin
        mac_ctrl.mul_en   = (state_reg == ST_MUL1) || (state_reg == ST_MUL2);
        mac_ctrl.acc_load = (state_reg == ST_MUL2);
        mac_ctrl.acc_add  = (state_reg == ST_ACC);
        if (state_reg == ST_MUL2)
        begin
            mac_a = diff_reg;
            mac_b = $signed({{(gspd_pkg::MUL_B_W - gspd_pkg::LIMIT_W){1'b0}}, dgain_reg});
        end
        else
        begin
            mac_a = gspd_pkg::MUL_A_W'(err_reg);
            mac_b = $signed({1'b0, kp_reg});
        end
    end

    gspd_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (mac_acc)
    );

    // Result: truncate toward zero, saturate, classify lock
    always_comb
    begin
        logic signed [gspd_pkg::ACC_W-1:0] q_full;
        logic signed [gspd_pkg::ACC_W-1:0] q_sat;
        logic [1:0]                        mode;
        if (mac_acc[gspd_pkg::ACC_W-1])
        begin
            q_full = (mac_acc + gspd_pkg::TRUNC_BIAS) >>> gspd_pkg::FRAC_W;
        end
        else
        begin
            q_full = mac_acc >>> gspd_pkg::FRAC_W;
        end
        if (q_full > gspd_pkg::STEER_MAX)
        begin
            q_sat = gspd_pkg::STEER_MAX;
        end
        else if (q_full < gspd_pkg::STEER_MIN)
        begin
            q_sat = gspd_pkg::STEER_MIN;
        end
        else
        begin
            q_sat = q_full;
        end
        if (mac_acc >= gspd_pkg::LOCK_Q12)
        begin
            mode = gspd_pkg::LOCK_LEFT;
        end
        else if (mac_acc <= gspd_pkg::LOCK_Q12_NEG)
        begin
            mode = gspd_pkg::LOCK_RIGHT;
        end
        else
        begin
            mode = gspd_pkg::LOCK_NONE;
        end

        if (hold_reg)
        begin
            result.steer_value  = (lock_mode_reg == gspd_pkg::LOCK_LEFT) ?
                                  gspd_pkg::LOCK_STEER : gspd_pkg::LOCK_STEER_NEG;
            result.held_at_lock = 1'b1;
            result.lock_state   = lock_mode_reg;
        end
        else
        begin
            result.steer_value  = q_sat[gspd_pkg::STEER_W-1:0];
            result.held_at_lock = 1'b0;
            result.lock_state   = mode;
        end
    end

    // Controller state update on a computed result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_mode_reg <= gspd_pkg::LOCK_NONE;
            prev_err_reg  <= '0;
        end
        else if (commit && !hold_reg)
        begin
            lock_mode_reg <= result.lock_state;
            prev_err_reg  <= err_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_reg <= result;
        end
    end

    // Checks
    a_lock_code: assert property (@(posedge clk) disable iff (!rst_n)
        lock_mode_reg != 2'b11)
        else $error("lock mode holds an unused code");

    a_hold_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && hold_reg) |=> ($stable(prev_err_reg) && $stable(lock_mode_reg)))
        else $error("held result changed controller state");

    a_hold_locked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.held_at_lock) |->
        ((out_data.lock_state == gspd_pkg::LOCK_LEFT &&
          out_data.steer_value == gspd_pkg::LOCK_STEER) ||
         (out_data.lock_state == gspd_pkg::LOCK_RIGHT &&
          out_data.steer_value == gspd_pkg::LOCK_STEER_NEG)))
        else $error("held result is not a full-lock value");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DEV))
        else $error("accepted transaction did not start the sequencer");

endmodule
